// File: rtl/cle_pkg.sv
// shared types and character constants of the console line editor
package cle_pkg;

    localparam int LEN_W = 7;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [7:0] CH_SPACE = 8'd32;

    typedef enum logic {
        ACT_CHAR = 1'b0,
        ACT_READ = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        KIND_ECHO      = 2'd0,
        KIND_LINE      = 2'd1,
        KIND_NOT_READY = 2'd2,
        KIND_REFUSED   = 2'd3
    } t_kind;

endpackage

// File: rtl/cle_in_if.sv
// input channel of the console line editor: characters and read requests
interface cle_in_if;
    logic                       valid;
    logic                       ready;
    cle_pkg::t_action           action;
    logic [7:0]                 rx_char;
    logic [cle_pkg::LEN_W-1:0]  read_len;

    modport source (output valid, action, rx_char, read_len, input ready);
    modport sink   (input valid, action, rx_char, read_len, output ready);
endinterface

// File: rtl/cle_out_if.sv
// result channel of the console line editor: echo, line and status bytes
interface cle_out_if;
    logic           valid;
    logic           ready;
    cle_pkg::t_kind kind;
    logic [7:0]     data;
    logic           last;

    modport source (output valid, kind, data, last, input ready);
    modport sink   (input valid, kind, data, last, output ready);
endinterface

// File: rtl/console_line_editor_core.sv
// console line editor core: canonical line editing over a line memory
//
// i_in carries one transaction per received character (action 0) or read
// request (action 1); o_out returns echo bytes, delivered line bytes and
// status results, with last set on the final result of each transaction.
// The line lives in a LINE_LEN x 8 synchronous memory with one write port
// and one registered read port; fill count, read position and the pending
// flag are registers.
// A character gives one echo or refused result, an erase three echo results
// (BS, space, BS) or none on an empty line, a read with no line pending one
// not-ready result. A pending read starts its first memory read on accept,
// then feeds the output register one byte per cycle while it is not stalled.
// i_in.ready is high only between transactions; a new transaction may be
// taken while the last result still waits in the output register.
// When the receiver stalls, the output register holds and the sequencer
// waits. Reset clears the fill count, read position, pending flag, state
// and output valid; the memory is not cleared, only written entries are read.
module console_line_editor_core #(
    parameter int LINE_LEN = 256,
    parameter int MAX_READ = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cle_in_if.sink            i_in,
    cle_out_if.source         o_out
);

    localparam int AW   = $clog2(LINE_LEN);
    localparam int CW   = $clog2(LINE_LEN + 1);
    localparam int NW   = $clog2(MAX_READ + 1);
    localparam int CMPW = (CW > cle_pkg::LEN_W) ? CW : cle_pkg::LEN_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ONE,
        S_ERASE,
        S_READ
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_fill;
    logic [CW-1:0]   r_pos;
    logic            r_pending;
    logic [NW-1:0]   r_left;
    logic [1:0]      r_step;
    cle_pkg::t_kind  r_hold_kind;
    logic [7:0]      r_hold_data;

    logic            r_out_valid;
    cle_pkg::t_kind  r_out_kind;
    logic [7:0]      r_out_data;
    logic            r_out_last;

    logic [7:0]      r_mem [LINE_LEN];
    logic [7:0]      r_mem_q;

    logic                      w_accept;
    logic                      w_out_free;
    logic [7:0]                w_char;
    logic                      w_is_erase;
    logic [CW-1:0]             w_fill_inc;
    logic [CW-1:0]             w_pos_inc;
    logic [cle_pkg::LEN_W-1:0] w_want;
    logic [CW-1:0]             w_avail;
    logic [CMPW-1:0]           w_want_x;
    logic [CMPW-1:0]           w_avail_x;
    logic [CMPW-1:0]           w_n_x;
    logic [NW-1:0]             w_n;
    logic                      w_wr_en;
    logic                      w_rd_en;
    logic [AW-1:0]             w_rd_addr;
    logic                      w_read_last;

    assign i_in.ready  = (r_state == S_IDLE);
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;

    assign o_out.valid = r_out_valid;
    assign o_out.kind  = r_out_kind;
    assign o_out.data  = r_out_data;
    assign o_out.last  = r_out_last;

    assign w_char     = (i_in.rx_char == cle_pkg::CH_CR) ? cle_pkg::CH_LF : i_in.rx_char;
    assign w_is_erase = (w_char == cle_pkg::CH_BS) || (w_char == cle_pkg::CH_DEL);
    assign w_fill_inc = r_fill + CW'(1);
    assign w_pos_inc  = r_pos + CW'(1);

    assign w_want    = (i_in.read_len > cle_pkg::LEN_W'(MAX_READ))
                       ? cle_pkg::LEN_W'(MAX_READ) : i_in.read_len;
    assign w_avail   = r_fill - r_pos;
    assign w_want_x  = CMPW'(w_want);
    assign w_avail_x = CMPW'(w_avail);
    assign w_n_x     = (w_want_x < w_avail_x) ? w_want_x : w_avail_x;
    assign w_n       = w_n_x[NW-1:0];

    assign w_read_last = (r_left == NW'(1));

    assign w_wr_en = w_accept && (i_in.action == cle_pkg::ACT_CHAR) && !r_pending
                     && !w_is_erase;

    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = r_pos[AW-1:0];
        if (w_accept && (i_in.action == cle_pkg::ACT_READ) && r_pending
            && (w_n != '0)) begin
            w_rd_en = 1'b1;
        end else if ((r_state == S_READ) && w_out_free && !w_read_last) begin
            w_rd_en   = 1'b1;
            w_rd_addr = w_pos_inc[AW-1:0];
        end
    end

    // line memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_fill[AW-1:0]] <= w_char;
        end
        if (w_rd_en) begin
            r_mem_q <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_pos       <= '0;
            r_pending   <= 1'b0;
            r_out_valid <= 1'b0;
            r_left      <= '0;
            r_step      <= '0;
        end else begin
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_in.action == cle_pkg::ACT_CHAR) begin
                            if (r_pending) begin
                                r_hold_kind <= cle_pkg::KIND_REFUSED;
                                r_hold_data <= '0;
                                r_state     <= S_ONE;
                            end else if (w_is_erase) begin
                                if (r_fill != '0) begin
                                    r_fill  <= r_fill - CW'(1);
                                    r_step  <= '0;
                                    r_state <= S_ERASE;
                                end
                            end else begin
                                r_fill      <= w_fill_inc;
                                r_hold_kind <= cle_pkg::KIND_ECHO;
                                r_hold_data <= w_char;
                                r_state     <= S_ONE;
                                if ((w_char == cle_pkg::CH_LF)
                                    || (w_fill_inc == CW'(LINE_LEN))) begin
                                    r_pending <= 1'b1;
                                    r_pos     <= '0;
                                end
                            end
                        end else begin
                            if (!r_pending) begin
                                r_hold_kind <= cle_pkg::KIND_NOT_READY;
                                r_hold_data <= '0;
                                r_state     <= S_ONE;
                            end else if (w_n != '0) begin
                                r_left  <= w_n;
                                r_state <= S_READ;
                            end
                        end
                    end
                end
                S_ONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= r_hold_kind;
                        r_out_data  <= r_hold_data;
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_ERASE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= cle_pkg::KIND_ECHO;
                        r_out_data  <= (r_step == 2'd1) ? cle_pkg::CH_SPACE : cle_pkg::CH_BS;
                        r_out_last  <= (r_step == 2'd2);
                        r_step      <= r_step + 2'd1;
                        if (r_step == 2'd2) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_READ: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= cle_pkg::KIND_LINE;
                        r_out_data  <= r_mem_q;
                        r_out_last  <= w_read_last;
                        r_left      <= r_left - NW'(1);
                        if (w_read_last) begin
                            r_state <= S_IDLE;
                            if (w_pos_inc >= r_fill) begin
                                r_pos     <= '0;
                                r_fill    <= '0;
                                r_pending <= 1'b0;
                            end else begin
                                r_pos <= w_pos_inc;
                            end
                        end else begin
                            r_pos <= w_pos_inc;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_pos_zero_collecting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_pending |-> (r_pos == '0))
        else $error("read position nonzero while collecting");

    a_pending_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending |-> (r_pos < r_fill))
        else $error("pending line with no bytes left");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_pending && (r_left != '0)
                                 && (CMPW'(r_left) <= CMPW'(r_fill - r_pos))))
        else $error("line read runs past the buffered bytes");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in.action == cle_pkg::ACT_CHAR) && !r_pending)
        |-> (r_fill < CW'(LINE_LEN)))
        else $error("character taken with a full buffer while collecting");

endmodule
